>>> src/sdtf_pkg.sv
// ----------------------------------------------------------------------------
// sdtf_pkg: shared types and constants of the signed decimal text formatter
// Transaction structs, ASCII codes and divide-by-ten constants.
// ----------------------------------------------------------------------------
package sdtf_pkg;

  // defaults for the top-level saturation limits
  localparam int MAX_WIDTH_DEF     = 64;
  localparam int MAX_PRECISION_DEF = 63;

  // a 32-bit magnitude has at most ten decimal digits
  localparam int DIGITS_MAX = 10;
  localparam int DIG_IDX_W  = 4;
  localparam int DIG_CNT_W  = 4;

  // q = (m * RECIP_10) >> RECIP_SHIFT is exact for every 32-bit m
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic signed [31:0] value;
    logic [6:0]         field_width;
    logic [5:0]         precision;
    logic               precision_given;
    logic               left_justify;
    logic               zero_pad;
    logic               force_plus;
    logic               space_sign;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_t;

  // status of the digit unit towards the sequencer
  typedef struct packed {
    logic                 done;
    logic [DIG_CNT_W-1:0] ndig;
  } conv_sts_t;

endpackage

>>> src/sdtf_div10_unit.sv
// ----------------------------------------------------------------------------
// sdtf_div10_unit: iterative binary to decimal digit extractor
// One reciprocal divide by ten per cycle, least significant digit first,
// digits kept in a small store for the sequencer to read back.
// ----------------------------------------------------------------------------
module sdtf_div10_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic                          skip,
  input  logic [31:0]                   mag,
  input  logic [sdtf_pkg::DIG_IDX_W-1:0] rd_idx,
  output logic [3:0]                    rd_digit,
  output sdtf_pkg::conv_sts_t           sts
);
  import sdtf_pkg::*;

  logic                 running_r, running_nxt;
  logic                 done_r, done_nxt;
  logic [DIG_CNT_W-1:0] ndig_r, ndig_nxt;
  logic [31:0]          m_r, m_nxt;
  logic [3:0]           dig_mem [DIGITS_MAX];

  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  ten_q_lo;
  logic [3:0]  dig;

  // remainder only needs the low nibble of m - 10q
  assign prod     = m_r * RECIP_10;
  assign quot     = 32'(prod[63:RECIP_SHIFT]);
  assign ten_q_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign dig      = m_r[3:0] - ten_q_lo;

  always_comb begin
    running_nxt = running_r;
    done_nxt    = 1'b0;
    ndig_nxt    = ndig_r;
    m_nxt       = m_r;
    if (go) begin
      m_nxt    = mag;
      ndig_nxt = '0;
      if (skip) begin
        done_nxt = 1'b1;
      end else begin
        running_nxt = 1'b1;
      end
    end else if (running_r) begin
      m_nxt    = quot;
      ndig_nxt = ndig_r + DIG_CNT_W'(1);
      if (quot == '0) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      ndig_r    <= '0;
    end else begin
      running_r <= running_nxt;
      done_r    <= done_nxt;
      ndig_r    <= ndig_nxt;
    end
    m_r <= m_nxt;
  end

  always_ff @(posedge clk) begin
    if (running_r && !go) begin
      dig_mem[ndig_r] <= dig;
    end
  end

  assign rd_digit = dig_mem[rd_idx];
  assign sts.done = done_r;
  assign sts.ndig = ndig_r;

  a_skip_gives_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
    go && skip |=> sts.done && sts.ndig == '0)
    else $error("skipped conversion did not finish empty");

  a_ndig_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> sts.ndig <= DIG_CNT_W'(DIGITS_MAX))
    else $error("digit count beyond ten");

  a_running_index_ok: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> ndig_r < DIG_CNT_W'(DIGITS_MAX))
    else $error("digit store index out of range");

endmodule

>>> src/signed_decimal_text_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_text_formatter: printf style %d text generator
// Converts one signed 32-bit value with its flags into ASCII characters.
// ----------------------------------------------------------------------------
//  channel  | ports                    | transfer
//  ---------+--------------------------+--------------------------------------
//  input    | start, busy, in_data     | taken when start high and busy low
//  result   | out_valid, out_data      | one character per strobe, no stall
//
//  per transaction: launch, then one decimal digit at a time in the
//  divide-by-ten unit (0 to 10 digits), length planning, then the characters
//  one after another (up to 64).
//  the strobe of the last character may overlap the next launch.
//  reset (rst_n low, synchronous) returns the sequencer to idle.
//  the receiver cannot stall; characters are emitted on consecutive cycles.
// ----------------------------------------------------------------------------
module signed_decimal_text_formatter #(
  parameter int MAX_WIDTH     = sdtf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PRECISION = sdtf_pkg::MAX_PRECISION_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sdtf_pkg::in_t in_data,
  output logic          out_valid,
  output sdtf_pkg::out_t out_data
);
  import sdtf_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int PW  = $clog2(MAX_PRECISION + 1);
  localparam int BW  = $clog2(MAX_PRECISION + 2);
  localparam int CW  = (WW > BW) ? WW : BW;
  localparam int NPH = 6;

  // text sections, in output order
  localparam int PH_LPAD = 0;
  localparam int PH_SIGN = 1;
  localparam int PH_ZPAD = 2;
  localparam int PH_PZ   = 3;
  localparam int PH_DIG  = 4;
  localparam int PH_RPAD = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PLAN,
    ST_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [WW-1:0]    width_r, width_nxt;
  logic [PW-1:0]    prec_r, prec_nxt;
  logic             prec_on_r, prec_on_nxt;
  logic             left_r, left_nxt;
  logic             zpad_r, zpad_nxt;
  logic             sign_on_r, sign_on_nxt;
  logic [7:0]       sign_ch_r, sign_ch_nxt;
  logic [CW-1:0]    ndig_r, ndig_nxt;
  logic [CW-1:0]    pz_r, pz_nxt;
  logic [CW-1:0]    pad_r, pad_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [NPH-1:0]   mask_r, mask_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic             conv_go;
  logic             conv_skip;
  logic [31:0]      conv_mag;
  conv_sts_t        conv_sts;
  logic [CW-1:0]    dig_pos;
  logic [3:0]       rd_digit;

  function automatic logic [CW-1:0] phase_len(input logic [NPH-1:0] oh,
                                              input logic [CW-1:0]  pad,
                                              input logic [CW-1:0]  pz,
                                              input logic [CW-1:0]  nd);
    logic [CW-1:0] len;
    len = '0;
    if (oh[PH_LPAD] || oh[PH_ZPAD] || oh[PH_RPAD]) begin
      len = pad;
    end else if (oh[PH_SIGN]) begin
      len = CW'(1);
    end else if (oh[PH_PZ]) begin
      len = pz;
    end else if (oh[PH_DIG]) begin
      len = nd;
    end
    return len;
  endfunction

  assign conv_go   = (state_r == ST_IDLE) && start;
  assign conv_skip = in_data.precision_given && (in_data.precision == '0) &&
                     (in_data.value == '0);
  assign conv_mag  = in_data.value[31] ? (32'd0 - in_data.value) : in_data.value;
  assign dig_pos   = cnt_r - CW'(1);

  sdtf_div10_unit u_div10 (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (conv_go),
    .skip     (conv_skip),
    .mag      (conv_mag),
    .rd_idx   (dig_pos[DIG_IDX_W-1:0]),
    .rd_digit (rd_digit),
    .sts      (conv_sts)
  );

  always_comb begin
    logic [CW-1:0]  body_c;
    logic [CW-1:0]  pad_c;
    logic [CW-1:0]  width_c;
    logic [CW-1:0]  prec_c;
    logic [CW-1:0]  nd_c;
    logic [NPH-1:0] mask_c;
    logic [NPH-1:0] lo_c;
    logic [NPH-1:0] rest_c;

    state_nxt     = state_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    prec_on_nxt   = prec_on_r;
    left_nxt      = left_r;
    zpad_nxt      = zpad_r;
    sign_on_nxt   = sign_on_r;
    sign_ch_nxt   = sign_ch_r;
    ndig_nxt      = ndig_r;
    pz_nxt        = pz_r;
    pad_nxt       = pad_r;
    cnt_nxt       = cnt_r;
    mask_nxt      = mask_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    width_c       = CW'(width_r);
    prec_c        = CW'(prec_r);
    nd_c          = CW'(conv_sts.ndig);
    body_c        = CW'(sign_on_r) + pz_r + ndig_r;
    pad_c         = (width_c > body_c) ? (width_c - body_c) : '0;
    mask_c        = '0;
    lo_c          = '0;
    rest_c        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          width_nxt   = (32'(in_data.field_width) > 32'(MAX_WIDTH)) ?
                        WW'(MAX_WIDTH) : WW'(in_data.field_width);
          prec_nxt    = (32'(in_data.precision) > 32'(MAX_PRECISION)) ?
                        PW'(MAX_PRECISION) : PW'(in_data.precision);
          prec_on_nxt = in_data.precision_given;
          left_nxt    = in_data.left_justify;
          // left-justify wins over zero padding, as does a given precision
          zpad_nxt    = in_data.zero_pad && !in_data.precision_given &&
                        !in_data.left_justify;
          sign_on_nxt = in_data.value[31] || in_data.force_plus || in_data.space_sign;
          if (in_data.value[31]) begin
            sign_ch_nxt = CHAR_MINUS;
          end else if (in_data.force_plus) begin
            sign_ch_nxt = CHAR_PLUS;
          end else begin
            sign_ch_nxt = CHAR_SPACE;
          end
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_sts.done) begin
          ndig_nxt  = nd_c;
          pz_nxt    = (prec_on_r && prec_c > nd_c) ? (prec_c - nd_c) : '0;
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        mask_c[PH_LPAD] = (pad_c != '0) && !left_r && !zpad_r;
        mask_c[PH_SIGN] = sign_on_r;
        mask_c[PH_ZPAD] = (pad_c != '0) && zpad_r;
        mask_c[PH_PZ]   = (pz_r != '0);
        mask_c[PH_DIG]  = (ndig_r != '0);
        mask_c[PH_RPAD] = (pad_c != '0) && left_r;
        lo_c      = mask_c & (~mask_c + NPH'(1));
        pad_nxt   = pad_c;
        mask_nxt  = mask_c;
        cnt_nxt   = phase_len(lo_c, pad_c, pz_r, ndig_r);
        // empty text gives no transaction at all
        state_nxt = (mask_c == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        lo_c   = mask_r & (~mask_r + NPH'(1));
        rest_c = mask_r & ~lo_c;
        out_valid_nxt = 1'b1;
        if (lo_c[PH_SIGN]) begin
          out_data_nxt.char_code = sign_ch_r;
        end else if (lo_c[PH_DIG]) begin
          out_data_nxt.char_code = CHAR_ZERO + {4'd0, rd_digit};
        end else if (lo_c[PH_ZPAD] || lo_c[PH_PZ]) begin
          out_data_nxt.char_code = CHAR_ZERO;
        end else begin
          out_data_nxt.char_code = CHAR_SPACE;
        end
        out_data_nxt.last = (cnt_r == CW'(1)) && (rest_c == '0);
        if (cnt_r == CW'(1)) begin
          mask_nxt  = rest_c;
          cnt_nxt   = phase_len(rest_c & (~rest_c + NPH'(1)), pad_r, pz_r, ndig_r);
          state_nxt = (rest_c == '0) ? ST_IDLE : ST_EMIT;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    prec_on_r  <= prec_on_nxt;
    left_r     <= left_nxt;
    zpad_r     <= zpad_nxt;
    sign_on_r  <= sign_on_nxt;
    sign_ch_r  <= sign_ch_nxt;
    ndig_r     <= ndig_nxt;
    pz_r       <= pz_nxt;
    pad_r      <= pad_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_idle_strobe_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_data.last)
    else $error("character left over after sequencer went idle");

  a_launch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("character strobe right after a launch");

  a_last_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("strobe continued past the last character");

  a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> mask_r != '0 && cnt_r != '0)
    else $error("emitting with no section pending");

endmodule

>>> tb/signed_decimal_text_formatter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_decimal_text_formatter_tb: self-checking bench for the %d formatter
// Sends directed and random signed values with flags, predicts the characters of
// each transaction and checks every strobed character and its last marker.
// ----------------------------------------------------------------------------
module signed_decimal_text_formatter_tb;
  import sdtf_pkg::*;

  localparam int TEXT_LIMIT  = 64;
  localparam int DRAIN_TICKS = 24;

  // tracks the characters owed by accepted transactions
  class formatted_text_board;
    out_t expected_chars[$];
    int   errors;
    int   values_taken;
    int   chars_checked;
    int   empty_texts;
    int   padded_zero_texts;

    function new();
      errors            = 0;
      values_taken      = 0;
      chars_checked     = 0;
      empty_texts       = 0;
      padded_zero_texts = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // builds the printf text of one value and queues it character by character
    function void note_value(in_t x);
      bit [7:0]  line[$];
      bit [7:0]  digs[DIGITS_MAX];
      bit [31:0] mag;
      bit [7:0]  sign_ch;
      bit        zfill;
      int        width;
      int        prec;
      int        ndig;
      int        sign_len;
      int        prec_zeros;
      int        body;
      int        pad;
      out_t      ch;

      values_taken++;
      mag = x.value;
      if (x.value[31]) begin
        mag = -mag;
      end
      width = int'(x.field_width);
      if (width > MAX_WIDTH_DEF) begin
        width = MAX_WIDTH_DEF;
      end
      prec = int'(x.precision);
      if (prec > MAX_PRECISION_DEF) begin
        prec = MAX_PRECISION_DEF;
      end

      sign_ch = 8'h00;
      if (x.value[31]) begin
        sign_ch = CHAR_MINUS;
      end else if (x.force_plus) begin
        sign_ch = CHAR_PLUS;
      end else if (x.space_sign) begin
        sign_ch = CHAR_SPACE;
      end
      sign_len = (sign_ch != 8'h00) ? 1 : 0;

      // an explicit precision of zero suppresses the lone zero digit
      ndig = 0;
      if (!(x.precision_given && prec == 0 && mag == 0)) begin
        do begin
          digs[ndig] = CHAR_ZERO + 8'(mag % 10);
          mag        = mag / 10;
          ndig++;
        end while (mag != 0 && ndig < DIGITS_MAX);
      end

      prec_zeros = (x.precision_given && prec > ndig) ? prec - ndig : 0;
      body       = sign_len + prec_zeros + ndig;
      pad        = (width > body) ? width - body : 0;
      zfill      = !x.left_justify && x.zero_pad && !x.precision_given;
      if (zfill && pad > 0) begin
        padded_zero_texts++;
      end

      if (!x.left_justify && !zfill) begin
        repeat (pad) line.push_back(CHAR_SPACE);
      end
      if (sign_len != 0) begin
        line.push_back(sign_ch);
      end
      if (zfill) begin
        repeat (pad) line.push_back(CHAR_ZERO);
      end
      repeat (prec_zeros) line.push_back(CHAR_ZERO);
      for (int i = ndig - 1; i >= 0; i--) begin
        line.push_back(digs[i]);
      end
      if (x.left_justify) begin
        repeat (pad) line.push_back(CHAR_SPACE);
      end
      while (line.size() > TEXT_LIMIT) begin
        void'(line.pop_back());
      end

      if (line.size() == 0) begin
        empty_texts++;
      end
      foreach (line[i]) begin
        ch.char_code = line[i];
        ch.last      = (i == line.size() - 1);
        expected_chars.push_back(ch);
      end
    endfunction

    function void check_char(out_t got);
      out_t want;

      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, actual char %h last %b",
                 $time, got.char_code, got.last);
        return;
      end
      want = expected_chars.pop_front();
      chars_checked++;
      if (got.char_code !== want.char_code) begin
        errors++;
        $display("%0t: char_code mismatch: expected %h, actual %h",
                 $time, want.char_code, got.char_code);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  formatted_text_board board = new();

  signed_decimal_text_formatter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout with %0d characters still owed", board.pending());
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_char(out_data);
    end
  end

  function automatic in_t make_value(logic signed [31:0] v, int w, int p, bit pg, bit lj,
                                     bit zp, bit fp, bit ss);
    in_t x;
    x.value           = v;
    x.field_width     = 7'(w);
    x.precision       = 6'(p);
    x.precision_given = pg;
    x.left_justify    = lj;
    x.zero_pad        = zp;
    x.force_plus      = fp;
    x.space_sign      = ss;
    return x;
  endfunction

  function automatic in_t random_value();
    in_t x;
    logic signed [31:0] edges[12] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 9, 10,
                                      -99, 100, 999_999_999, 1_000_000_000,
                                      -1_000_000_000};
    case ($urandom_range(9))
      0, 1:    x.value = $urandom;
      2, 3, 4: x.value = $urandom_range(999);
      5:       x.value = edges[$urandom_range(11)];
      default: x.value = $urandom_range(99_999);
    endcase
    if ($urandom_range(1) && x.value > 0) begin
      x.value = -x.value;
    end
    case ($urandom_range(19))
      0:         x.field_width = 7'($urandom_range(127));
      1, 2, 3:   x.field_width = 7'($urandom_range(64));
      default:   x.field_width = 7'($urandom_range(20));
    endcase
    x.precision       = ($urandom_range(9) < 7) ? 6'($urandom_range(12)) :
                                                  6'($urandom_range(63));
    x.precision_given = 1'($urandom_range(1));
    x.left_justify    = 1'($urandom_range(1));
    x.zero_pad        = 1'($urandom_range(1));
    x.force_plus      = 1'($urandom_range(1));
    x.space_sign      = 1'($urandom_range(1));
    return x;
  endfunction

  // holds start high until the block takes the transaction
  task automatic send_value(in_t x, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= x;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    board.note_value(x);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
  endtask

  initial begin
    in_t directed[$];
    int  idle_mix[4] = '{0, 80, 14, 0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_value(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_value(32'sh8000_0000, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_value(32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 1, 0));
    directed.push_back(make_value(-1, 5, 0, 0, 0, 0, 0, 0));
    // zero with precision zero: nothing, sign only, sign and padding, padding only
    directed.push_back(make_value(0, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(make_value(0, 0, 0, 1, 0, 0, 1, 0));
    directed.push_back(make_value(0, 5, 0, 1, 0, 0, 0, 1));
    directed.push_back(make_value(0, 5, 0, 1, 1, 0, 0, 0));
    directed.push_back(make_value(-42, 12, 0, 0, 0, 1, 0, 0));
    // left justify wins over zero pad and keeps the sign
    directed.push_back(make_value(-42, 12, 0, 0, 1, 1, 0, 0));
    directed.push_back(make_value(42, 12, 5, 1, 0, 1, 0, 0));
    directed.push_back(make_value(42, 8, 0, 0, 0, 0, 0, 1));
    directed.push_back(make_value(42, 8, 0, 0, 0, 1, 1, 1));
    directed.push_back(make_value(7, 127, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_value(7, 100, 0, 0, 1, 0, 1, 0));
    directed.push_back(make_value(-5, 64, 63, 1, 0, 0, 0, 0));
    directed.push_back(make_value(123, 10, 63, 0, 0, 1, 0, 0));
    directed.push_back(make_value(32'sh8000_0000, 64, 0, 0, 0, 1, 0, 0));
    directed.push_back(make_value(32'sh7FFF_FFFF, 20, 12, 1, 1, 0, 0, 1));
    directed.push_back(make_value(5, 0, 63, 1, 0, 0, 0, 0));
    directed.push_back(make_value(1_000_000_000, 3, 1, 1, 0, 0, 0, 0));
    foreach (directed[i]) begin
      send_value(directed[i], 0);
    end
    wait_drained();

    foreach (idle_mix[p]) begin
      repeat (100) send_value(random_value(), idle_mix[p]);
      // after the mostly idle phase, let every owed character arrive before the next
      if (p == 1) begin
        wait_drained();
      end
    end
    wait_drained();

    $display("covered %0d values with %0d characters checked", board.values_taken,
             board.chars_checked);
    $display("%0d produced empty text, %0d used zero padding", board.empty_texts,
             board.padded_zero_texts);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
